/* hw/rtl/ilid_pkg.sv */
// Shared types, codes and default constants for the indexed list unit.
package ilid_pkg;

    // Default sizing
    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_DATA_WIDTH  = 32;

    // Fixed port widths
    localparam int OP_WIDTH     = 3;
    localparam int INDEX_WIDTH  = 6;
    localparam int VALUE_WIDTH  = 32;
    localparam int STATUS_WIDTH = 2;
    localparam int COUNT_WIDTH  = 7;
    localparam int CFG_WIDTH    = 7;

    // Capacity after reset and reset value of the initial capacity register
    localparam int RESET_CAPACITY = 10;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_EDIT   = 3'd2,
        OP_DELETE = 3'd3,
        OP_READ   = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_INDEX = 2'd1,
        STS_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOOP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_RESP
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the request
        logic check;     // evaluate status, single-word write, pointer init
        logic shift_rd;  // read the element that moves next
        logic shift_wr;  // write it one place over, step the pointer
        logic put;       // write the inserted word
        logic finish;    // commit count and capacity, present the result
    } ilid_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic ok;        // request passes index and full checks
        logic more;      // shift loop has another element to move
        op_t  op;        // latched operation
    } ilid_sts_t;

endpackage

/* hw/rtl/indexed_list_insert_delete_unit.sv */
// Top level of the indexed list unit: ordered word list with insert, delete, edit and read.
//
// Usage:
//   Request channel: present op, index and value with start; the request is taken at
//   a rising edge where start is high and busy is low. busy stays high until the
//   result cycle, in which a new request may already be taken.
//   Result channel: done is high for exactly one cycle with status, read_value, count
//   and capacity_now valid; the receiver must take it then, it cannot stall.
//   Config channel: cfg_data loads the capacity used by clear; cfg_ready is always
//   high, write only while no request is in flight.
// Sequence: every request is checked, then answered; a good insert or delete shifts the
//   later elements in between, and insert then writes its word. Each moved element
//   takes a read, a write and a loop test on the single write port / single read port
//   element RAM.
// Reset: count 0, capacity min(10, MAX_ENTRIES), clear capacity 10. Element RAM is not
//   cleared; only positions below count are ever read.
module indexed_list_insert_delete_unit
    import ilid_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [OP_WIDTH-1:0]           op,
    input  logic [INDEX_WIDTH-1:0]        index,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_WIDTH-1:0]          cfg_data,
    output logic                          done,
    output logic [STATUS_WIDTH-1:0]       status,
    output logic signed [VALUE_WIDTH-1:0] read_value,
    output logic [COUNT_WIDTH-1:0]        count,
    output logic [COUNT_WIDTH-1:0]        capacity_now
);

    ilid_cmd_t cmd;
    ilid_sts_t sts;

    assign cfg_ready = 1'b1;

    ilid_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    ilid_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .op           (op),
        .index        (index),
        .value        (value),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .read_value   (read_value),
        .count        (count),
        .capacity_now (capacity_now)
    );

endmodule

/* hw/rtl/ilid_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ilid_ram
    import ilid_pkg::*;
#(
    parameter int WIDTH = DEF_DATA_WIDTH,
    parameter int DEPTH = DEF_MAX_ENTRIES
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/ilid_ctrl.sv */
// Sequencer for the indexed list unit: walks each request through check, shift and response.
module ilid_ctrl
    import ilid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ilid_sts_t sts,
    output ilid_cmd_t cmd,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.ok && (sts.op == OP_INSERT || sts.op == OP_DELETE))
                begin
                    state_next = S_LOOP;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_LOOP:
            begin
                if (sts.more)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (sts.op == OP_INSERT)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR: state_next = S_LOOP;
            S_PUT:      state_next = S_RESP;
            S_RESP:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            S_CHECK:    cmd.check    = 1'b1;
            S_LOOP:     cmd          = '0;
            S_SHIFT_RD: cmd.shift_rd = 1'b1;
            S_SHIFT_WR: cmd.shift_wr = 1'b1;
            S_PUT:      cmd.put      = 1'b1;
            S_RESP:     cmd.finish   = 1'b1;
            default:    cmd          = '0;
        endcase
    end

endmodule

/* hw/rtl/ilid_dpath.sv */
// Datapath for the indexed list unit: element store, count, capacity and result registers.
module ilid_dpath
    import ilid_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ilid_cmd_t               cmd,
    output ilid_sts_t               sts,
    input  logic [OP_WIDTH-1:0]     op,
    input  logic [INDEX_WIDTH-1:0]  index,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                    cfg_valid,
    input  logic [CFG_WIDTH-1:0]    cfg_data,
    output logic                    done,
    output logic [STATUS_WIDTH-1:0] status,
    output logic signed [VALUE_WIDTH-1:0] read_value,
    output logic [COUNT_WIDTH-1:0]  count,
    output logic [COUNT_WIDTH-1:0]  capacity_now
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int XW0  = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;
    localparam int XW1  = (XW0 > CFG_WIDTH) ? XW0 : CFG_WIDTH;
    localparam int XW   = XW1 + 1;
    localparam int RCAP = (RESET_CAPACITY < MAX_ENTRIES) ? RESET_CAPACITY : MAX_ENTRIES;
    localparam logic [XW-1:0] MAX_X = XW'(MAX_ENTRIES);

    // Request and list state
    op_t                           op_reg;
    logic [INDEX_WIDTH-1:0]        index_reg;
    logic signed [DATA_WIDTH-1:0]  word_reg;
    status_t                       status_reg;
    status_t                       status_next;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [CW-1:0]                 cap_reg;
    logic [CW-1:0]                 cap_next;
    logic [CW-1:0]                 ptr_reg;
    logic [CFG_WIDTH-1:0]          init_cap_reg;
    logic                          done_reg;
    logic signed [VALUE_WIDTH-1:0] rd_val_reg;

    // Extended views for compares
    logic [XW-1:0] idx_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] cap_x;
    logic [XW-1:0] ptr_x;
    logic [XW-1:0] init_x;
    logic [XW-1:0] grow_x;
    logic [XW-1:0] half_x;
    logic [XW-1:0] clear_cap_x;

    // RAM port
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic signed [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic signed [DATA_WIDTH-1:0] ram_rdata;

    assign idx_x  = XW'(index_reg);
    assign cnt_x  = XW'(count_reg);
    assign cap_x  = XW'(cap_reg);
    assign ptr_x  = XW'(ptr_reg);
    assign init_x = XW'(init_cap_reg);
    assign grow_x = ((cap_x << 1) > MAX_X) ? MAX_X : (cap_x << 1);
    assign half_x = cap_x >> 1;

    always_comb
    begin
        if (init_x == '0)
        begin
            clear_cap_x = XW'(1);
        end
        else if (init_x > MAX_X)
        begin
            clear_cap_x = MAX_X;
        end
        else
        begin
            clear_cap_x = init_x;
        end
    end

    // Index and full checks
    always_comb
    begin
        status_next = STS_OK;
        case (op_reg)
            OP_APPEND:
            begin
                if (cnt_x >= MAX_X)
                begin
                    status_next = STS_FULL;
                end
            end
            OP_INSERT:
            begin
                if (idx_x > cnt_x)
                begin
                    status_next = STS_BAD_INDEX;
                end
                else if (cnt_x >= MAX_X)
                begin
                    status_next = STS_FULL;
                end
            end
            OP_EDIT, OP_DELETE, OP_READ:
            begin
                if (idx_x >= cnt_x)
                begin
                    status_next = STS_BAD_INDEX;
                end
            end
            default: status_next = STS_OK;
        endcase
    end

    // Status toward the controller
    always_comb
    begin
        sts.op = op_reg;
        sts.ok = (status_next == STS_OK);
        if (op_reg == OP_INSERT)
        begin
            sts.more = (ptr_x > idx_x);
        end
        else
        begin
            sts.more = ((ptr_x + XW'(1)) < cnt_x);
        end
    end

    // Count and capacity after a successful request
    always_comb
    begin
        count_next = count_reg;
        cap_next   = cap_reg;
        if (status_reg == STS_OK)
        begin
            case (op_reg)
                OP_APPEND, OP_INSERT:
                begin
                    count_next = count_reg + CW'(1);
                    if (cnt_x >= cap_x)
                    begin
                        cap_next = CW'(grow_x);
                    end
                end
                OP_DELETE:
                begin
                    count_next = count_reg - CW'(1);
                    if ((cnt_x - XW'(1)) == half_x)
                    begin
                        cap_next = (half_x == '0) ? CW'(1) : CW'(half_x);
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                    cap_next   = CW'(clear_cap_x);
                end
                default:
                begin
                    count_next = count_reg;
                    cap_next   = cap_reg;
                end
            endcase
        end
    end

    // Store port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(index_reg);
        ram_wdata = word_reg;
        if (cmd.shift_rd)
        begin
            ram_raddr = (op_reg == OP_INSERT) ? AW'(ptr_reg - CW'(1)) : AW'(ptr_reg + CW'(1));
        end
        else
        begin
            ram_raddr = AW'(index_reg);
        end
        if (cmd.check && status_next == STS_OK)
        begin
            if (op_reg == OP_APPEND)
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_reg);
            end
            else if (op_reg == OP_EDIT)
            begin
                ram_we = 1'b1;
            end
        end
        else if (cmd.shift_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(ptr_reg);
            ram_wdata = ram_rdata;
        end
        else if (cmd.put)
        begin
            ram_we = 1'b1;
        end
    end

    ilid_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Request payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op_t'(op);
            index_reg <= index;
            word_reg  <= DATA_WIDTH'(value);
        end
        if (cmd.check)
        begin
            status_reg <= status_next;
            ptr_reg    <= (op_reg == OP_INSERT) ? count_reg : CW'(index_reg);
        end
        else if (cmd.shift_wr)
        begin
            ptr_reg <= (op_reg == OP_INSERT) ? (ptr_reg - CW'(1)) : (ptr_reg + CW'(1));
        end
        if (cmd.finish)
        begin
            if (op_reg == OP_READ && status_reg == STS_OK)
            begin
                rd_val_reg <= VALUE_WIDTH'(ram_rdata);
            end
            else
            begin
                rd_val_reg <= '0;
            end
        end
    end

    // List state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            cap_reg      <= CW'(RCAP);
            init_cap_reg <= CFG_WIDTH'(RESET_CAPACITY);
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                count_reg <= count_next;
                cap_reg   <= cap_next;
            end
            if (cfg_valid)
            begin
                init_cap_reg <= cfg_data;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign read_value   = rd_val_reg;
    assign count        = COUNT_WIDTH'(count_reg);
    assign capacity_now = COUNT_WIDTH'(cap_reg);

endmodule
